// File: rtl/core/fwe_pkg.sv
// Shared types, frame constants and check-byte helpers for the firmware frame encoder.
// Used by every module under rtl/core except fwe_ram; depends on nothing else.
`default_nettype none

package fwe_pkg;

    // Sizing
    localparam int PAYLOAD_BYTES_DEFAULT = 64;
    localparam int FILL_W                = 7;   // holds 0..64 bytes of one data area
    localparam int LEN_W                 = 24;
    localparam int SUM_W                 = 32;
    localparam int POS_W                 = 7;   // byte position 0..69 in a frame
    localparam int CMD_QUEUE_DEPTH       = 2;

    // Frame layout
    localparam int FRAME_LEN  = 70;
    localparam int DATA_POS   = 4;
    localparam int DATA_AREA  = 64;
    localparam int CHECK_POS  = 68;
    localparam int WORD_BYTES = 8;
    localparam int LAST_WORD_BYTES = 6;

    // Frame byte codes
    localparam logic [7:0] FRM_HEADER   = 8'h20;
    localparam logic [7:0] FRM_SEQUENCE = 8'hFF;
    localparam logic [7:0] CMD_DATA     = 8'h31;
    localparam logic [7:0] CMD_TRAILER  = 8'h32;
    localparam logic [7:0] FRM_LENGTH   = 8'(DATA_AREA);
    localparam logic [7:0] FRM_END      = 8'h03;

    // Input operations
    localparam logic OP_IMAGE   = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // One queued job: an optional data frame, then an optional trailer frame
    typedef struct packed {
        logic              has_data;
        logic              has_trl;
        logic              bank;
        logic [FILL_W-1:0] fill;
        logic [7:0]        dcheck;
        logic [LEN_W-1:0]  length;
        logic [SUM_W-1:0]  sum;
    } cmd_t;

    // Back end hands a buffer bank back to the front end
    typedef struct packed {
        logic valid;
        logic bank;
    } release_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DATA,
        BK_TRAILER
    } back_state_t;

    // Check byte of a data frame from the XOR of its held bytes
    function automatic logic [7:0] data_check(input logic [7:0] run_xor);
        return ~(FRM_SEQUENCE ^ CMD_DATA ^ FRM_LENGTH ^ run_xor);
    endfunction

    // Check byte of a trailer frame carrying length and sum big-endian
    function automatic logic [7:0] trailer_check(input logic [LEN_W-1:0] length,
                                                 input logic [SUM_W-1:0] sum);
        logic [7:0] x;
        x = FRM_SEQUENCE ^ CMD_TRAILER ^ FRM_LENGTH;
        x = x ^ length[23:16] ^ length[15:8] ^ length[7:0];
        x = x ^ sum[31:24] ^ sum[23:16] ^ sum[15:8] ^ sum[7:0];
        return ~x;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/fwe_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Stands alone; no package use.
`default_nettype none

module fwe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/fwe_front.sv
// Front end: takes input transfers, keeps counts, sum and XOR, writes image bytes
// to the frame buffer and queues frame jobs. Depends on fwe_pkg.
`default_nettype none

module fwe_front #(
    parameter int PAYLOAD_BYTES = fwe_pkg::PAYLOAD_BYTES_DEFAULT,
    parameter int IDX_W         = $clog2(PAYLOAD_BYTES),
    parameter int RAM_AW        = IDX_W + 1
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // input channel
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         op,
    input  wire logic [7:0]                   image_byte,
    // length register
    input  wire logic                         cfg_valid,
    input  wire logic [fwe_pkg::LEN_W-1:0]    image_length,
    // frame buffer write
    output logic                              ram_we,
    output logic [RAM_AW-1:0]                 ram_waddr,
    output logic [7:0]                        ram_wdata,
    // job queue
    input  wire logic                         q_full,
    output logic                              q_push,
    output fwe_pkg::cmd_t                     q_cmd,
    // bank bookkeeping
    input  wire fwe_pkg::release_t            release_bank,
    output logic [1:0]                        bank_busy
);

    localparam logic [fwe_pkg::FILL_W-1:0] FLUSH_AT = fwe_pkg::FILL_W'(PAYLOAD_BYTES);

    logic [fwe_pkg::LEN_W-1:0]  len_reg,  len_next;
    logic [fwe_pkg::FILL_W-1:0] fill_reg, fill_next;
    logic [fwe_pkg::LEN_W-1:0]  sent_reg, sent_next;
    logic [fwe_pkg::SUM_W-1:0]  sum_reg,  sum_next;
    logic [7:0]                 xor_reg,  xor_next;
    logic                       done_reg, done_next;
    logic                       bank_reg, bank_next;
    logic [1:0]                 busy_reg, busy_next;

    logic                       accept;
    logic [fwe_pkg::FILL_W-1:0] inc_fill;
    logic [fwe_pkg::LEN_W-1:0]  inc_sent;
    logic [fwe_pkg::SUM_W-1:0]  inc_sum;
    logic [7:0]                 inc_xor;
    logic                       flush;
    logic                       reach;
    logic [1:0]                 busy_set;
    logic [1:0]                 busy_clr;

    // Hold input while the queue is full or the fill bank is still being sent
    assign in_stall  = q_full || busy_reg[bank_reg];
    assign accept    = in_valid && !in_stall;
    assign bank_busy = busy_reg;

    assign inc_fill = fill_reg + fwe_pkg::FILL_W'(1);
    assign inc_sent = sent_reg + fwe_pkg::LEN_W'(1);
    assign inc_sum  = sum_reg + fwe_pkg::SUM_W'(image_byte);
    assign inc_xor  = xor_reg ^ image_byte;
    assign flush    = (inc_fill >= FLUSH_AT) || (inc_sent == len_reg);
    assign reach    = (inc_sent == len_reg);

    // Classify the transfer and build the job
    always_comb
    begin
        len_next  = cfg_valid ? image_length : len_reg;
        fill_next = fill_reg;
        sent_next = sent_reg;
        sum_next  = sum_reg;
        xor_next  = xor_reg;
        done_next = done_reg;
        bank_next = bank_reg;
        busy_set  = 2'b00;
        busy_clr  = 2'b00;
        ram_we    = 1'b0;
        ram_waddr = {bank_reg, fill_reg[IDX_W-1:0]};
        ram_wdata = image_byte;
        q_push    = 1'b0;
        q_cmd     = '0;
        q_cmd.bank   = bank_reg;
        q_cmd.length = len_reg;

        if (release_bank.valid)
        begin
            busy_clr[release_bank.bank] = 1'b1;
        end

        if (accept)
        begin
            if (op == fwe_pkg::OP_RESTART)
            begin
                fill_next = '0;
                sent_next = '0;
                sum_next  = '0;
                xor_next  = '0;
                done_next = 1'b0;
            end
            else if (!done_reg)
            begin
                if (sent_reg >= len_reg)
                begin
                    // length already reached: flush what is held, then send the trailer
                    q_push         = 1'b1;
                    q_cmd.has_data = (fill_reg != '0);
                    q_cmd.has_trl  = 1'b1;
                    q_cmd.fill     = fill_reg;
                    q_cmd.dcheck   = fwe_pkg::data_check(xor_reg);
                    q_cmd.sum      = sum_reg;
                    done_next      = 1'b1;
                    fill_next      = '0;
                    xor_next       = '0;
                    if (fill_reg != '0)
                    begin
                        busy_set[bank_reg] = 1'b1;
                        bank_next          = !bank_reg;
                    end
                end
                else
                begin
                    // store the byte and advance the counts
                    ram_we    = 1'b1;
                    sent_next = inc_sent;
                    sum_next  = inc_sum;
                    q_cmd.has_data = flush;
                    q_cmd.has_trl  = reach;
                    q_cmd.fill     = inc_fill;
                    q_cmd.dcheck   = fwe_pkg::data_check(inc_xor);
                    q_cmd.sum      = inc_sum;
                    q_push         = flush;
                    if (flush)
                    begin
                        busy_set[bank_reg] = 1'b1;
                        bank_next          = !bank_reg;
                        fill_next          = '0;
                        xor_next           = '0;
                    end
                    else
                    begin
                        fill_next = inc_fill;
                        xor_next  = inc_xor;
                    end
                    if (reach)
                    begin
                        done_next = 1'b1;
                    end
                end
            end
        end

        busy_next = (busy_reg & ~busy_clr) | busy_set;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            fill_reg <= '0;
            sent_reg <= '0;
            sum_reg  <= '0;
            xor_reg  <= '0;
            done_reg <= 1'b0;
            bank_reg <= 1'b0;
            busy_reg <= 2'b00;
        end
        else
        begin
            len_reg  <= len_next;
            fill_reg <= fill_next;
            sent_reg <= sent_next;
            sum_reg  <= sum_next;
            xor_reg  <= xor_next;
            done_reg <= done_next;
            bank_reg <= bank_next;
            busy_reg <= busy_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/fwe_cmd_queue.sv
// Short job queue between the front and back ends of the frame encoder.
// Depends on fwe_pkg for the job type and depth.
`default_nettype none

module fwe_cmd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire fwe_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output fwe_pkg::cmd_t      head_cmd,
    output logic               empty,
    output logic               full
);

    localparam int DEPTH = fwe_pkg::CMD_QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fwe_pkg::cmd_t    slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign head_cmd = slot_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed jobs
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/fwe_back.sv
// Back end: builds data and trailer frames byte by byte from queued jobs and the
// frame buffer, and sends them as nine words each. Depends on fwe_pkg.
`default_nettype none

module fwe_back #(
    parameter int PAYLOAD_BYTES = fwe_pkg::PAYLOAD_BYTES_DEFAULT,
    parameter int IDX_W         = $clog2(PAYLOAD_BYTES),
    parameter int RAM_AW        = IDX_W + 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // job queue
    input  wire logic              q_empty,
    input  wire fwe_pkg::cmd_t     q_head,
    output logic                   q_pop,
    // frame buffer read
    output logic                   ram_re,
    output logic [RAM_AW-1:0]      ram_raddr,
    input  wire logic [7:0]        ram_rdata,
    // bank handed back after its data frame
    output fwe_pkg::release_t      release_bank,
    // output channel
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [63:0]            frame_word,
    output logic [3:0]             byte_count,
    output logic                   end_of_frame,
    output logic                   trailer_frame,
    output logic                   last_of_run
);

    localparam logic [fwe_pkg::POS_W-1:0] LAST_POS  = fwe_pkg::POS_W'(fwe_pkg::FRAME_LEN - 1);
    localparam logic [fwe_pkg::POS_W-1:0] DATA_POS  = fwe_pkg::POS_W'(fwe_pkg::DATA_POS);
    localparam logic [fwe_pkg::POS_W-1:0] CHECK_POS = fwe_pkg::POS_W'(fwe_pkg::CHECK_POS);

    fwe_pkg::back_state_t        state_reg, state_next;
    fwe_pkg::cmd_t               cur_reg,   cur_next;
    logic [fwe_pkg::POS_W-1:0]   pos_reg,   pos_next;
    logic                        hold_reg,  hold_next;
    logic                        ld_valid_reg, ld_valid_next;
    logic [fwe_pkg::POS_W-1:0]   ld_pos_reg,   ld_pos_next;
    logic [63:0]                 asm_reg,      asm_next;
    logic                        asm_done_reg, asm_done_next;
    logic                        out_valid_reg, out_valid_next;
    logic [63:0]                 word_reg,  word_next;
    logic [3:0]                  count_reg, count_next;
    logic                        eof_reg,   eof_next;
    logic                        trl_reg,   trl_next;
    logic                        last_reg,  last_next;

    logic                        out_take;
    logic                        is_trl;
    logic                        last_word;
    logic [fwe_pkg::POS_W-1:0]   rd_idx;
    logic [7:0]                  land_byte;

    // True on the final byte of a frame word
    function automatic logic word_end(input logic [fwe_pkg::POS_W-1:0] pos);
        return (pos[2:0] == 3'd7) || (pos == LAST_POS);
    endfunction

    // Frame byte at a position, from the current job and buffer read data
    function automatic logic [7:0] frame_byte(input logic [fwe_pkg::POS_W-1:0] pos,
                                              input logic                      trl,
                                              input fwe_pkg::cmd_t             cmd,
                                              input logic [7:0]                rdata);
        logic [fwe_pkg::POS_W-1:0] d;
        logic [31:0]               len_w;
        logic [7:0]                b;
        d     = pos - DATA_POS;
        len_w = {8'h00, cmd.length};
        b     = 8'h00;
        if (pos == fwe_pkg::POS_W'(0))
        begin
            b = fwe_pkg::FRM_HEADER;
        end
        else if (pos == fwe_pkg::POS_W'(1))
        begin
            b = fwe_pkg::FRM_SEQUENCE;
        end
        else if (pos == fwe_pkg::POS_W'(2))
        begin
            b = trl ? fwe_pkg::CMD_TRAILER : fwe_pkg::CMD_DATA;
        end
        else if (pos == fwe_pkg::POS_W'(3))
        begin
            b = fwe_pkg::FRM_LENGTH;
        end
        else if (pos == CHECK_POS)
        begin
            b = trl ? fwe_pkg::trailer_check(cmd.length, cmd.sum) : cmd.dcheck;
        end
        else if (pos == LAST_POS)
        begin
            b = fwe_pkg::FRM_END;
        end
        else if (trl)
        begin
            if (d < fwe_pkg::POS_W'(4))
            begin
                b = len_w[8 * (3 - d[1:0]) +: 8];
            end
            else if (d < fwe_pkg::POS_W'(8))
            begin
                b = cmd.sum[8 * (3 - d[1:0]) +: 8];
            end
        end
        else if (d < cmd.fill)
        begin
            b = rdata;
        end
        return b;
    endfunction

    assign out_take  = out_valid_reg && !out_stall;
    assign is_trl    = (state_reg == fwe_pkg::BK_TRAILER);
    assign last_word = (pos_reg == LAST_POS);
    assign rd_idx    = pos_reg - DATA_POS;
    assign ram_raddr = {cur_reg.bank, rd_idx[IDX_W-1:0]};
    assign land_byte = frame_byte(ld_pos_reg, is_trl, cur_reg, ram_rdata);

    assign out_valid     = out_valid_reg;
    assign frame_word    = word_reg;
    assign byte_count    = count_reg;
    assign end_of_frame  = eof_reg;
    assign trailer_frame = trl_reg;
    assign last_of_run   = last_reg;

    // Sequencer: issue reads, land bytes, hand finished words to the output register
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        pos_next       = pos_reg;
        hold_next      = hold_reg;
        ld_valid_next  = 1'b0;
        ld_pos_next    = ld_pos_reg;
        asm_next       = asm_reg;
        asm_done_next  = asm_done_reg;
        out_valid_next = out_valid_reg;
        word_next      = word_reg;
        count_next     = count_reg;
        eof_next       = eof_reg;
        trl_next       = trl_reg;
        last_next      = last_reg;
        q_pop          = 1'b0;
        ram_re         = 1'b0;
        release_bank   = '0;

        if (out_take)
        begin
            out_valid_next = 1'b0;
        end

        // land the byte read in the previous cycle
        if (ld_valid_reg)
        begin
            asm_next[8 * ld_pos_reg[2:0] +: 8] = land_byte;
            if (word_end(ld_pos_reg))
            begin
                asm_done_next = 1'b1;
            end
        end

        case (state_reg)
            fwe_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_head;
                    pos_next   = '0;
                    hold_next  = 1'b0;
                    state_next = q_head.has_data ? fwe_pkg::BK_DATA : fwe_pkg::BK_TRAILER;
                end
            end
            fwe_pkg::BK_DATA, fwe_pkg::BK_TRAILER:
            begin
                if (!hold_reg)
                begin
                    // issue one byte position
                    ram_re        = 1'b1;
                    ld_valid_next = 1'b1;
                    ld_pos_next   = pos_reg;
                    if (word_end(pos_reg))
                    begin
                        hold_next = 1'b1;
                    end
                    else
                    begin
                        pos_next = pos_reg + fwe_pkg::POS_W'(1);
                    end
                end
                else if (asm_done_reg && (!out_valid_reg || out_take))
                begin
                    // transfer the finished word to the output register
                    out_valid_next = 1'b1;
                    word_next      = asm_reg;
                    count_next     = last_word ? 4'(fwe_pkg::LAST_WORD_BYTES)
                                               : 4'(fwe_pkg::WORD_BYTES);
                    eof_next       = last_word;
                    trl_next       = is_trl;
                    last_next      = last_word && (is_trl || !cur_reg.has_trl);
                    asm_next       = '0;
                    asm_done_next  = 1'b0;
                    hold_next      = 1'b0;
                    pos_next       = pos_reg + fwe_pkg::POS_W'(1);
                    if (last_word)
                    begin
                        pos_next = '0;
                        if (is_trl)
                        begin
                            state_next = fwe_pkg::BK_IDLE;
                        end
                        else
                        begin
                            release_bank.valid = 1'b1;
                            release_bank.bank  = cur_reg.bank;
                            state_next = cur_reg.has_trl ? fwe_pkg::BK_TRAILER
                                                         : fwe_pkg::BK_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = fwe_pkg::BK_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fwe_pkg::BK_IDLE;
            pos_reg       <= '0;
            hold_reg      <= 1'b0;
            ld_valid_reg  <= 1'b0;
            asm_done_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            hold_reg      <= hold_next;
            ld_valid_reg  <= ld_valid_next;
            asm_done_reg  <= asm_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        ld_pos_reg <= ld_pos_next;
        asm_reg    <= asm_next;
        word_reg   <= word_next;
        count_reg  <= count_next;
        eof_reg    <= eof_next;
        trl_reg    <= trl_next;
        last_reg   <= last_next;
    end

endmodule

`default_nettype wire

// File: rtl/core/firmware_frame_encoder_unit.sv
// Top level of the firmware frame encoder: front end, job queue, frame buffer RAM
// and back end. Depends on fwe_pkg, fwe_front, fwe_cmd_queue, fwe_ram and fwe_back.
//
// Image bytes are taken one per cycle while the job queue has room and the buffer
// bank being filled is not still in flight; the frame buffer is double-banked so a
// new frame fills while the previous one is sent. The back end reads the frame
// buffer one byte per cycle through the single RAM read port, pausing at the end
// of each word to hand it to the output register; the final byte of the image
// can raise up to eighteen words (a data frame and the trailer frame). Restarts
// and ignored bytes give no words. The frame buffer needs no clearing after reset.
// The length register may be written at any time through the configuration
// channel, which is always ready.
`default_nettype none

module firmware_frame_encoder_unit #(
    parameter int PAYLOAD_BYTES = fwe_pkg::PAYLOAD_BYTES_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // length register write channel
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [fwe_pkg::LEN_W-1:0]  image_length,
    // input channel
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       op,
    input  wire logic [7:0]                 image_byte,
    // output channel
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [63:0]                     frame_word,
    output logic [3:0]                      byte_count,
    output logic                            end_of_frame,
    output logic                            trailer_frame,
    output logic                            last_of_run
);

    localparam int IDX_W     = $clog2(PAYLOAD_BYTES);
    localparam int RAM_AW    = IDX_W + 1;
    localparam int RAM_DEPTH = 2 ** RAM_AW;

    logic                cfg_write;
    logic                ram_we;
    logic [RAM_AW-1:0]   ram_waddr;
    logic [7:0]          ram_wdata;
    logic                ram_re;
    logic [RAM_AW-1:0]   ram_raddr;
    logic [7:0]          ram_rdata;
    logic                q_full;
    logic                q_empty;
    logic                q_push;
    logic                q_pop;
    fwe_pkg::cmd_t       q_cmd;
    fwe_pkg::cmd_t       q_head;
    fwe_pkg::release_t   release_bank;
    logic [1:0]          bank_busy;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    fwe_front #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .IDX_W         (IDX_W),
        .RAM_AW        (RAM_AW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .image_byte   (image_byte),
        .cfg_valid    (cfg_write),
        .image_length (image_length),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_cmd),
        .release_bank (release_bank),
        .bank_busy    (bank_busy)
    );

    fwe_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head_cmd (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    fwe_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_frame_buffer (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fwe_back #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .IDX_W         (IDX_W),
        .RAM_AW        (RAM_AW)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .release_bank  (release_bank),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_word    (frame_word),
        .byte_count    (byte_count),
        .end_of_frame  (end_of_frame),
        .trailer_frame (trailer_frame),
        .last_of_run   (last_of_run)
    );

    // Never overwrite a bank whose frame is still queued or being sent
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !bank_busy[ram_waddr[RAM_AW-1]])
    else $error("frame buffer write into a busy bank");

    // Only a busy bank is handed back
    assert property (@(posedge clk) disable iff (!rst_n)
        release_bank.valid |-> bank_busy[release_bank.bank])
    else $error("release of a bank that is not busy");

    // Short word exactly at the end of a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (end_of_frame == (byte_count == 4'(fwe_pkg::LAST_WORD_BYTES))))
    else $error("byte count does not match end of frame");

    // A run always ends on a frame boundary
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_of_run) |-> end_of_frame)
    else $error("last word of run is not the end of a frame");

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for firmware_frame_encoder_unit: directed table, then random phases.
// Depends on fwe_pkg and the RTL under rtl/core; expected words come from a predictor in this file.
`timescale 1ns / 1ps

module tb;

    localparam int PAYLOAD       = fwe_pkg::PAYLOAD_BYTES_DEFAULT;
    localparam int RANDOM_ITEMS  = 300;
    localparam int SETTLE_CYCLES = 250;
    localparam int PRESSURE_HOLD = 1000;
    localparam int STALL_LIMIT   = 8000;

    // Typed words of a trailer frame with zero length and zero sum
    localparam logic [63:0] BARE_HEAD = 64'h0000_0000_4032_FF20;
    localparam logic [63:0] BARE_TAIL = 64'h0000_0372_0000_0000;

    typedef struct packed {
        logic [63:0] frame_word;
        logic [3:0]  byte_count;
        logic        end_of_frame;
        logic        trailer_frame;
        logic        last_of_run;
    } word_t;

    typedef enum logic [1:0] {
        ROW_LENGTH,        // write the length register
        ROW_MODEL,         // send item, expect what the predictor gives
        ROW_NOTHING,       // send item, expect no words
        ROW_BARE_TRAILER   // send item, expect a zero-length trailer frame
    } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic        item_op;
        logic [7:0]  item_byte;
        logic [23:0] length;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [23:0] image_length;
    logic        in_valid;
    logic        in_stall;
    logic        op;
    logic [7:0]  image_byte;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] frame_word;
    logic [3:0]  byte_count;
    logic        end_of_frame;
    logic        trailer_frame;
    logic        last_of_run;

    // Predictor state
    logic [23:0] want_length = '0;
    logic [7:0]  held_bytes [0:63];
    int          held_count = 0;
    logic [23:0] taken_count = '0;
    logic [31:0] image_sum = '0;
    logic        trailer_sent = 1'b0;
    logic [7:0]  frame_bytes [0:fwe_pkg::FRAME_LEN-1];

    word_t fresh_words [$];
    word_t pending_words [$];
    row_t  directed_rows [$];

    int errors = 0;
    int items_sent = 0;
    int restarts_sent = 0;
    int lengths_written = 0;
    int words_checked = 0;
    int frames_seen = 0;
    int trailers_seen = 0;
    logic sender_calm = 1'b0;
    logic receiver_calm = 1'b0;
    logic pressure_req = 1'b0;

    firmware_frame_encoder_unit #(
        .PAYLOAD_BYTES(PAYLOAD)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .image_length (image_length),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .image_byte   (image_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_word   (frame_word),
        .byte_count   (byte_count),
        .end_of_frame (end_of_frame),
        .trailer_frame(trailer_frame),
        .last_of_run  (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Clear a frame and fill in header, sequence, command, length and end byte
    function automatic void start_frame(input logic [7:0] cmd);
        int i;
        for (i = 0; i < fwe_pkg::FRAME_LEN; i++)
            frame_bytes[i] = 8'h00;
        frame_bytes[0] = fwe_pkg::FRM_HEADER;
        frame_bytes[1] = fwe_pkg::FRM_SEQUENCE;
        frame_bytes[2] = cmd;
        frame_bytes[3] = fwe_pkg::FRM_LENGTH;
        frame_bytes[fwe_pkg::FRAME_LEN-1] = fwe_pkg::FRM_END;
    endfunction

    // Seal the check byte and cut the frame into nine words
    function automatic void emit_frame(input logic is_trailer);
        int w;
        int b;
        int n;
        logic [7:0] x;
        word_t word;
        x = 8'h00;
        for (b = 1; b < fwe_pkg::CHECK_POS; b++)
            x = x ^ frame_bytes[b];
        frame_bytes[fwe_pkg::CHECK_POS] = ~x;
        for (w = 0; w < 9; w++)
        begin
            n = (w == 8) ? fwe_pkg::LAST_WORD_BYTES : fwe_pkg::WORD_BYTES;
            word.frame_word = '0;
            for (b = 0; b < n; b++)
                word.frame_word[8*b +: 8] = frame_bytes[8*w + b];
            word.byte_count    = 4'(n);
            word.end_of_frame  = (w == 8);
            word.trailer_frame = is_trailer;
            word.last_of_run   = 1'b0;
            fresh_words.push_back(word);
        end
    endfunction

    function automatic void flush_held();
        int i;
        start_frame(fwe_pkg::CMD_DATA);
        for (i = 0; i < held_count; i++)
            frame_bytes[fwe_pkg::DATA_POS + i] = held_bytes[i];
        held_count = 0;
        emit_frame(1'b0);
    endfunction

    function automatic void emit_trailer();
        int i;
        logic [31:0] len32;
        len32 = 32'(want_length);
        start_frame(fwe_pkg::CMD_TRAILER);
        for (i = 0; i < 4; i++)
        begin
            frame_bytes[fwe_pkg::DATA_POS + i]     = len32[31 - 8*i -: 8];
            frame_bytes[fwe_pkg::DATA_POS + 4 + i] = image_sum[31 - 8*i -: 8];
        end
        trailer_sent = 1'b1;
        emit_frame(1'b1);
    endfunction

    // Advance the predictor by one input item; the words it causes land in fresh_words
    function automatic void encode_item(input logic item_op, input logic [7:0] item_byte);
        word_t tail;
        fresh_words.delete();
        if (item_op == fwe_pkg::OP_RESTART)
        begin
            held_count   = 0;
            taken_count  = '0;
            image_sum    = '0;
            trailer_sent = 1'b0;
        end
        else if (!trailer_sent)
        begin
            if (taken_count >= want_length)
            begin
                // length already reached: flush what is held, then close the image
                if (held_count > 0)
                    flush_held();
                emit_trailer();
            end
            else
            begin
                held_bytes[held_count] = item_byte;
                held_count++;
                taken_count = taken_count + 24'd1;
                image_sum   = image_sum + 32'(item_byte);
                if (held_count >= PAYLOAD || taken_count == want_length)
                    flush_held();
                if (taken_count == want_length)
                    emit_trailer();
            end
        end
        if (fresh_words.size() > 0)
        begin
            tail = fresh_words.pop_back();
            tail.last_of_run = 1'b1;
            fresh_words.push_back(tail);
        end
    endfunction

    function automatic void add_row(input row_kind_t kind, input logic item_op,
                                    input logic [7:0] item_byte, input logic [23:0] length);
        row_t r;
        r.kind      = kind;
        r.item_op   = item_op;
        r.item_byte = item_byte;
        r.length    = length;
        directed_rows.push_back(r);
    endfunction

    // Offer one item after a random gap and hold it until the transfer completes
    task automatic send_item(input logic item_op, input logic [7:0] item_byte,
                             input logic use_prediction);
        int gap;
        logic taken;
        int i;
        if ($urandom_range(0, 29) == 0)
            sender_calm = !sender_calm;
        gap = sender_calm ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        op         <= item_op;
        image_byte <= item_byte;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        encode_item(item_op, item_byte);
        if (use_prediction)
            for (i = 0; i < fresh_words.size(); i++)
                pending_words.push_back(fresh_words[i]);
        items_sent++;
        if (item_op == fwe_pkg::OP_RESTART)
            restarts_sent++;
    endtask

    // Drop valid, drain every expected word, then let the block go quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input logic [23:0] value);
        logic taken;
        settle();
        cfg_valid    <= 1'b1;
        image_length <= value;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        cfg_valid   <= 1'b0;
        want_length  = value;
        lengths_written++;
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] seen);
        if (seen !== want)
        begin
            errors++;
            $display("%0t: %s expected %h, got %h", $time, name, want, seen);
        end
    endtask

    // Output side: random stall, one long hold on request, field-by-field check
    initial
    begin : drain_words
        word_t seen;
        word_t want;
        int hold;
        logic got;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
                receiver_calm = !receiver_calm;
            if (pressure_req)
            begin
                hold = PRESSURE_HOLD;
                pressure_req = 1'b0;
            end
            else
                hold = receiver_calm ? 0 : $urandom_range(0, 13);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
            begin
                @(negedge clk);
                got                = out_valid;
                seen.frame_word    = frame_word;
                seen.byte_count    = byte_count;
                seen.end_of_frame  = end_of_frame;
                seen.trailer_frame = trailer_frame;
                seen.last_of_run   = last_of_run;
                @(posedge clk);
            end
            while (got !== 1'b1);
            if (pending_words.size() == 0)
            begin
                errors++;
                $display("%0t: word %h arrived with nothing expected", $time, seen.frame_word);
            end
            else
            begin
                want = pending_words.pop_front();
                compare_field("frame_word", want.frame_word, seen.frame_word);
                compare_field("byte_count", 64'(want.byte_count), 64'(seen.byte_count));
                compare_field("end_of_frame", 64'(want.end_of_frame), 64'(seen.end_of_frame));
                compare_field("trailer_frame", 64'(want.trailer_frame),
                              64'(seen.trailer_frame));
                compare_field("last_of_run", 64'(want.last_of_run), 64'(seen.last_of_run));
            end
            words_checked++;
            if (seen.end_of_frame)
            begin
                frames_seen++;
                if (seen.trailer_frame)
                    trailers_seen++;
            end
        end
    end

    // End the run if no transfer happens for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(negedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[firmware_frame_encoder_unit] ERROR");
        $finish;
    end

    // Stimulus: reset, directed table, random phases, drain and report
    initial
    begin : stimulus
        row_t r;
        word_t w;
        int k;
        int scenario;
        int run;
        int split;
        int random_items;
        logic first;
        logic [23:0] len;

        rst_n        <= 1'b0;
        cfg_valid    <= 1'b0;
        image_length <= '0;
        in_valid     <= 1'b0;
        op           <= fwe_pkg::OP_IMAGE;
        image_byte   <= 8'h00;

        // length is zero after reset, so the first byte closes an empty image
        add_row(ROW_BARE_TRAILER, fwe_pkg::OP_IMAGE, 8'h00, '0);
        add_row(ROW_NOTHING, fwe_pkg::OP_IMAGE, 8'hFF, '0);       // byte after the trailer
        add_row(ROW_NOTHING, fwe_pkg::OP_RESTART, 8'hFF, '0);
        add_row(ROW_BARE_TRAILER, fwe_pkg::OP_IMAGE, 8'hA5, '0);
        add_row(ROW_NOTHING, fwe_pkg::OP_RESTART, 8'h00, '0);
        add_row(ROW_LENGTH, fwe_pkg::OP_IMAGE, 8'h00, 24'd1);
        add_row(ROW_MODEL, fwe_pkg::OP_IMAGE, 8'hFF, '0);  // one-byte data frame plus trailer
        add_row(ROW_NOTHING, fwe_pkg::OP_IMAGE, 8'h00, '0);
        add_row(ROW_NOTHING, fwe_pkg::OP_RESTART, 8'h00, '0);
        add_row(ROW_LENGTH, fwe_pkg::OP_IMAGE, 8'h00, 24'd3);
        add_row(ROW_MODEL, fwe_pkg::OP_IMAGE, 8'h00, '0);
        add_row(ROW_MODEL, fwe_pkg::OP_IMAGE, 8'hFF, '0);
        add_row(ROW_MODEL, fwe_pkg::OP_IMAGE, 8'h80, '0);
        add_row(ROW_NOTHING, fwe_pkg::OP_RESTART, 8'h00, '0);
        add_row(ROW_LENGTH, fwe_pkg::OP_IMAGE, 8'h00, 24'd10);
        add_row(ROW_MODEL, fwe_pkg::OP_IMAGE, 8'h01, '0);
        add_row(ROW_MODEL, fwe_pkg::OP_IMAGE, 8'h02, '0);
        add_row(ROW_MODEL, fwe_pkg::OP_IMAGE, 8'h03, '0);
        // lower the length below what was taken: held bytes flush, then the trailer
        add_row(ROW_LENGTH, fwe_pkg::OP_IMAGE, 8'h00, 24'd2);
        add_row(ROW_MODEL, fwe_pkg::OP_IMAGE, 8'h55, '0);
        add_row(ROW_NOTHING, fwe_pkg::OP_RESTART, 8'h00, '0);
        add_row(ROW_LENGTH, fwe_pkg::OP_IMAGE, 8'h00, 24'hFF_FFFF);
        add_row(ROW_MODEL, fwe_pkg::OP_IMAGE, 8'h7F, '0);
        add_row(ROW_MODEL, fwe_pkg::OP_IMAGE, 8'h80, '0);
        add_row(ROW_MODEL, fwe_pkg::OP_IMAGE, 8'h01, '0);
        add_row(ROW_NOTHING, fwe_pkg::OP_RESTART, 8'h00, '0);     // held bytes are dropped
        add_row(ROW_LENGTH, fwe_pkg::OP_IMAGE, 8'h00, 24'd0);
        add_row(ROW_BARE_TRAILER, fwe_pkg::OP_IMAGE, 8'h00, '0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            if (r.kind == ROW_LENGTH)
                write_length(r.length);
            else
            begin
                send_item(r.item_op, r.item_byte, r.kind == ROW_MODEL);
                if (r.kind == ROW_BARE_TRAILER)
                    for (k = 0; k < 9; k++)
                    begin
                        w.frame_word    = (k == 0) ? BARE_HEAD : (k == 8) ? BARE_TAIL : 64'h0;
                        w.byte_count    = (k == 8) ? 4'd6 : 4'd8;
                        w.end_of_frame  = (k == 8);
                        w.trailer_frame = 1'b1;
                        w.last_of_run   = (k == 8);
                        pending_words.push_back(w);
                    end
            end
        end

        // Random phases: new length, mostly a restart, then a run of bytes with some noise
        random_items = 0;
        first = 1'b1;
        while (random_items < RANDOM_ITEMS)
        begin
            scenario = first ? 1 : $urandom_range(0, 9);
            case (scenario)
                0:
                begin
                    len = '0;
                    run = $urandom_range(1, 4);
                end
                1:
                begin
                    len = 24'hFF_FFFF;
                    run = first ? 160 : $urandom_range(65, 130);
                end
                2:
                begin
                    len = 24'($urandom) | 24'h80_0000;
                    run = $urandom_range(65, 130);
                end
                default:
                begin
                    len = 24'($urandom_range(1, 100));
                    run = int'(len) + $urandom_range(0, 3);
                end
            endcase
            write_length(len);
            if (first || $urandom_range(0, 3) != 0)
                send_item(fwe_pkg::OP_RESTART, 8'($urandom), 1'b1);
            if (first)
            begin
                // fill the block while the output side holds off
                sender_calm  = 1'b1;
                pressure_req = 1'b1;
            end
            split = (scenario > 2 && $urandom_range(0, 3) == 0) ?
                    $urandom_range(1, int'(len)) : -1;
            for (k = 0; k < run && random_items < RANDOM_ITEMS; k++)
            begin
                if (k == split)
                    write_length(24'($urandom_range(0, split)));
                if ($urandom_range(0, 39) == 0)
                    send_item(fwe_pkg::OP_RESTART, 8'($urandom), 1'b1);
                else
                    send_item(fwe_pkg::OP_IMAGE, 8'($urandom), 1'b1);
                random_items++;
            end
            first = 1'b0;
        end

        settle();
        $display("Sent %0d items (%0d restarts) over %0d length settings.",
                 items_sent, restarts_sent, lengths_written);
        $display("Checked %0d words in %0d frames, %0d of them trailers.",
                 words_checked, frames_seen, trailers_seen);
        if (errors == 0 && pending_words.size() == 0)
            $display("[firmware_frame_encoder_unit] OK");
        else
            $display("[firmware_frame_encoder_unit] ERROR");
        $finish;
    end

endmodule
